// ===== rtl/core/dq_pkg.sv =====
`timescale 1ns / 1ps
// shared constants, codes and control types for the deque core
// no dependencies; imported by dq_cell and deque_with_indexed_read_core
package dq_pkg;

	localparam int DEPTH   = 16;
	localparam int ITEM_W  = 32;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int POS_W   = 4;
	localparam int STAT_W  = 2;
	localparam int OP_W    = 3;
	localparam int CNTO_W  = 5;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH_FRONT = 3'd0,
		OP_PUSH_BACK  = 3'd1,
		OP_POP_FRONT  = 3'd2,
		OP_POP_BACK   = 3'd3,
		OP_READ       = 3'd4
	} opcode_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2,
		ST_RANGE = 2'd3
	} status_t;

	// what every cell of the row does in one cycle
	typedef enum logic [1:0] {
		CM_HOLD        = 2'd0,
		CM_SHIFT_BACK  = 2'd1,
		CM_SHIFT_FRONT = 2'd2,
		CM_WRITE_AT    = 2'd3
	} cell_mode_t;

	typedef struct packed {
		cell_mode_t        mode;
		logic [IDX_W-1:0]  wr_idx;
		logic              rd_en;
		logic [IDX_W-1:0]  rd_idx;
	} cell_ctrl_t;

endpackage

// ===== rtl/core/deque_with_indexed_read_core.sv =====
`timescale 1ns / 1ps
// top level of the bounded deque with indexed read
// depends on dq_pkg and dq_cell
//
// Bounded double-ended queue of DEPTH 32-bit words. Each input word carries
// one command: push front, push back, pop front, pop back, or read at a
// position counted from the front. Every command returns exactly one output
// word with the popped or read item, a status (ok, full, empty, out of
// range), the count after the command and an empty flag. The storage is a
// row of cells ordered front to back: push front shifts the whole row one
// cell toward the back, pop front shifts it toward the front, push back
// writes the cell at the current count, and reads pick one cell by index.
// One command is taken per clock; its result sits in an output register the
// next cycle, and a new command is taken whenever that register is empty or
// being drained in the same cycle, so throughput is one command per cycle
// limited only by backpressure on the output. Opcodes 5 to 7 change nothing
// and answer ok with a zero item.
module deque_with_indexed_read_core
	import dq_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,   // opcode[2:0], item_in[34:3], position[38:35], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [39:0] m_tdata    // item_out[31:0], status[33:32], count_now[38:34],
	                               // is_empty[39]
);

	// input word fields
	logic [OP_W-1:0]   opcode;
	logic [ITEM_W-1:0] item_in;
	logic [POS_W-1:0]  position;

	assign opcode   = s_tdata[2:0];
	assign item_in  = s_tdata[34:3];
	assign position = s_tdata[38:35];

	// occupancy
	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_d;

	// output register
	logic              m_tvalid_q;
	logic [ITEM_W-1:0] item_out_q;
	status_t           status_q;
	logic [CNTO_W-1:0] count_out_q;
	logic              empty_q;

	logic accept;
	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	logic is_full;
	logic is_zero;
	logic [CNT_W-1:0] pos_ext;
	logic [CNT_W-1:0] last_c;
	assign is_full = (count_q == CNT_W'(DEPTH));
	assign is_zero = (count_q == '0);
	assign pos_ext = CNT_W'(position);
	assign last_c  = count_q - CNT_W'(1);

	// command decode
	cell_ctrl_t ctrl;
	status_t    status_d;

	always_comb begin
		ctrl.mode   = CM_HOLD;
		ctrl.wr_idx = count_q[IDX_W-1:0];
		ctrl.rd_en  = 1'b0;
		ctrl.rd_idx = '0;
		status_d    = ST_OK;
		count_d     = count_q;
		case (opcode)
			OP_PUSH_FRONT: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.mode = CM_SHIFT_BACK;
					count_d   = count_q + CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (is_full) begin
					status_d = ST_FULL;
				end else begin
					ctrl.mode = CM_WRITE_AT;
					count_d   = count_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (is_zero) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.mode   = CM_SHIFT_FRONT;
					ctrl.rd_en  = 1'b1;
					ctrl.rd_idx = '0;
					count_d     = last_c;
				end
			end
			OP_POP_BACK: begin
				if (is_zero) begin
					status_d = ST_EMPTY;
				end else begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_idx = last_c[IDX_W-1:0];
					count_d     = last_c;
				end
			end
			OP_READ: begin
				if (pos_ext >= count_q) begin
					status_d = ST_RANGE;
				end else begin
					ctrl.rd_en  = 1'b1;
					ctrl.rd_idx = pos_ext[IDX_W-1:0];
				end
			end
			default: begin
				status_d = ST_OK;
			end
		endcase
		// a stalled slave side leaves the row untouched
		if (!accept) begin
			ctrl.mode  = CM_HOLD;
			ctrl.rd_en = 1'b0;
		end
	end

	// row of cells, cell 0 is the front
	logic [ITEM_W-1:0] cell_val [DEPTH];
	logic [ITEM_W-1:0] cell_tap [DEPTH];

	genvar gi;
	generate
		for (gi = 0; gi < DEPTH; gi++) begin : g_cell
			logic [ITEM_W-1:0] left_v;
			logic [ITEM_W-1:0] right_v;
			if (gi == 0) begin : g_first
				assign left_v = item_in;
			end else begin : g_mid
				assign left_v = cell_val[gi-1];
			end
			if (gi == DEPTH - 1) begin : g_last
				assign right_v = cell_val[gi];
			end else begin : g_inner
				assign right_v = cell_val[gi+1];
			end
			dq_cell u_cell (
				.clk       (clk),
				.ctrl      (ctrl),
				.idx       (IDX_W'(gi)),
				.left_val  (left_v),
				.right_val (right_v),
				.item      (item_in),
				.value     (cell_val[gi]),
				.tap       (cell_tap[gi])
			);
		end
	endgenerate

	// at most one tap is live; the rest are zero
	logic [ITEM_W-1:0] rd_word;
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < DEPTH; i++) begin
			rd_word = rd_word | cell_tap[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q    <= count_d;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			item_out_q  <= rd_word;
			status_q    <= status_d;
			count_out_q <= CNTO_W'(count_d);
			empty_q     <= (count_d == '0);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {empty_q, count_out_q, status_q, item_out_q};

	// occupancy never passes the capacity
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("deque count above capacity");

	// a refused push only happens at full capacity
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q == ST_FULL) |-> (count_out_q == CNTO_W'(DEPTH)))
		else $error("full status with room left");

	// any error status returns a zero item
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid_q && status_q != ST_OK) |-> (item_out_q == '0))
		else $error("nonzero item on error status");

	// a pop from an empty deque leaves it empty
	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_zero && (opcode == OP_POP_FRONT || opcode == OP_POP_BACK))
		|=> (count_q == '0))
		else $error("empty pop changed count");

	// empty flag agrees with the reported count
	a_empty_flag: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> (empty_q == (count_out_q == '0)))
		else $error("empty flag disagrees with count");

endmodule

// ===== rtl/core/dq_cell.sv =====
`timescale 1ns / 1ps
// one deque cell: holds the word at its position from the front
// depends on dq_pkg
module dq_cell
	import dq_pkg::*;
(
	input  logic              clk,
	input  cell_ctrl_t        ctrl,
	input  logic [IDX_W-1:0]  idx,
	input  logic [ITEM_W-1:0] left_val,   // neighbor nearer the front (new item at cell 0)
	input  logic [ITEM_W-1:0] right_val,  // neighbor nearer the back
	input  logic [ITEM_W-1:0] item,
	output logic [ITEM_W-1:0] value,
	output logic [ITEM_W-1:0] tap
);

	logic [ITEM_W-1:0] value_q;
	logic [ITEM_W-1:0] value_d;

	always_comb begin
		value_d = value_q;
		case (ctrl.mode)
			CM_SHIFT_BACK:  value_d = left_val;
			CM_SHIFT_FRONT: value_d = right_val;
			CM_WRITE_AT:    if (ctrl.wr_idx == idx) value_d = item;
			default:        value_d = value_q;
		endcase
	end

	always_ff @(posedge clk) begin
		value_q <= value_d;
	end

	assign value = value_q;
	// read tap, or-ed across the row
	assign tap = (ctrl.rd_en && ctrl.rd_idx == idx) ? value_q : '0;

endmodule
